@@ hdl/macs_pkg.sv @@
// Shared types, constants and register map for the moving average crossover block.
// Used by every other file of the block except macs_intf; depends on nothing.
`timescale 1ns / 1ps

package macs_pkg;

   localparam int unsigned MAX_WINDOW_DEF = 16;

   localparam int unsigned PRICE_W   = 32;
   localparam int unsigned WIN_REG_W = 5;
   localparam int unsigned BAL_W     = 32;
   localparam int unsigned QTY_W     = 16;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned BAL_SHIFT = 8;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [WIN_REG_W-1:0] FAST_WINDOW_RST     = 5'd5;
   localparam logic [WIN_REG_W-1:0] SLOW_WINDOW_RST     = 5'd10;
   localparam logic [BAL_W-1:0]     ACCOUNT_BALANCE_RST = 32'd2560000;
   localparam logic [QTY_W-1:0]     ORDER_QUANTITY_RST  = 16'd2560;

   typedef enum logic [1:0] {
      REG_FAST_WINDOW     = 2'd0,
      REG_SLOW_WINDOW     = 2'd1,
      REG_ACCOUNT_BALANCE = 2'd2,
      REG_ORDER_QUANTITY  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_HOLD = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_CAPITAL = 2'd1,
      CAUSE_PRICE   = 2'd2
   } cause_type;

   typedef struct packed {
      logic [WIN_REG_W-1:0] fast_window;
      logic [WIN_REG_W-1:0] slow_window;
      logic [BAL_W-1:0]     account_balance;
      logic [QTY_W-1:0]     order_quantity;
   } cfg_type;

endpackage

@@ hdl/macs_intf.sv @@
// Valid/ready channel interfaces for tick prices and trade decisions.
// Depends on nothing; field widths follow the package constants.
`timescale 1ns / 1ps

interface macs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] price;

   modport source (output valid, output price, input ready);
   modport sink   (input valid, input price, output ready);
endinterface

interface macs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        accepted;
   logic [1:0]  reject_cause;
   logic [31:0] order_number;
   logic [31:0] executed_count;

   modport source (output valid, output action, output accepted, output reject_cause,
                   output order_number, output executed_count, input ready);
   modport sink   (input valid, input action, input accepted, input reject_cause,
                   input order_number, input executed_count, output ready);
endinterface

@@ hdl/macs_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// Depends on macs_pkg for default sizes only.
`timescale 1ns / 1ps

module macs_ram #(
   parameter int unsigned WIDTH = macs_pkg::PRICE_W,
   parameter int unsigned DEPTH = macs_pkg::MAX_WINDOW_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

@@ hdl/macs_csr.sv @@
// APB-style configuration registers: window lengths, balance limit, order quantity.
// Depends on macs_pkg for the register map and cfg_type.
`timescale 1ns / 1ps

module macs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [macs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [macs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [macs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output macs_pkg::cfg_type                   cfg,
   output logic                                win_wr
);
   import macs_pkg::*;

   reg_index_type        index;
   logic                 wr_en;
   logic [WIN_REG_W-1:0] fast_ff, fast_in;
   logic [WIN_REG_W-1:0] slow_ff, slow_in;
   logic [BAL_W-1:0]     bal_ff, bal_in;
   logic [QTY_W-1:0]     qty_ff, qty_in;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign win_wr = wr_en && ((index == REG_FAST_WINDOW) || (index == REG_SLOW_WINDOW));

   always_comb begin
      fast_in = fast_ff;
      slow_in = slow_ff;
      bal_in  = bal_ff;
      qty_in  = qty_ff;
      if (wr_en) begin
         unique case (index)
            REG_FAST_WINDOW:     fast_in = pwdata[WIN_REG_W-1:0];
            REG_SLOW_WINDOW:     slow_in = pwdata[WIN_REG_W-1:0];
            REG_ACCOUNT_BALANCE: bal_in  = pwdata[BAL_W-1:0];
            REG_ORDER_QUANTITY:  qty_in  = pwdata[QTY_W-1:0];
            default:             fast_in = fast_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= FAST_WINDOW_RST;
         slow_ff <= SLOW_WINDOW_RST;
         bal_ff  <= ACCOUNT_BALANCE_RST;
         qty_ff  <= ORDER_QUANTITY_RST;
      end else begin
         fast_ff <= fast_in;
         slow_ff <= slow_in;
         bal_ff  <= bal_in;
         qty_ff  <= qty_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_FAST_WINDOW:     prdata = CSR_DATA_W'(fast_ff);
         REG_SLOW_WINDOW:     prdata = CSR_DATA_W'(slow_ff);
         REG_ACCOUNT_BALANCE: prdata = CSR_DATA_W'(bal_ff);
         REG_ORDER_QUANTITY:  prdata = CSR_DATA_W'(qty_ff);
         default:             prdata = '0;
      endcase
   end

   assign cfg.fast_window     = fast_ff;
   assign cfg.slow_window     = slow_ff;
   assign cfg.account_balance = bal_ff;
   assign cfg.order_quantity  = qty_ff;

endmodule

@@ hdl/macs_core.sv @@
// Price window, running fast/slow sums, crossover decision, risk check and counters.
// Depends on macs_pkg, macs_intf and macs_ram.
`timescale 1ns / 1ps

module macs_core #(
   parameter int unsigned MAX_WINDOW = macs_pkg::MAX_WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   macs_req_if.sink          req_ch,
   macs_rsp_if.source        rsp_ch,
   input  macs_pkg::cfg_type cfg,
   input  logic              win_wr
);
   import macs_pkg::*;

   localparam int unsigned AW     = $clog2(MAX_WINDOW);
   localparam int unsigned WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned XW     = WIN_W + 1;
   localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 2);
   localparam int unsigned SUM_W  = PRICE_W + $clog2(MAX_WINDOW);
   localparam int unsigned PROD_W = SUM_W + WIN_W + 1;
   localparam int unsigned COST_W = PRICE_W + QTY_W + 1;

   function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [WIN_W-1:0] w);
      logic [XW-1:0] ax;
      logic [XW-1:0] wx;
      logic [XW-1:0] diff;
      ax = XW'(a);
      wx = XW'(w);
      if (ax >= wx) begin
         diff = ax - wx;
      end else begin
         diff = ax + XW'(MAX_WINDOW) - wx;
      end
      return diff[AW-1:0];
   endfunction

   logic [WIN_W-1:0]          fw, sw;
   logic                      out_free, advance, accept;

   logic                      in_valid_ff, in_valid_in;
   logic signed [PRICE_W-1:0] in_price_ff;

   logic [AW-1:0]             wp_ff, wp_in, wp_inc;
   logic [WIN_W-1:0]          fill_ff, fill_in, fill_next;
   logic signed [SUM_W-1:0]   fsum_ff, fsum_in, ssum_ff, ssum_in;
   logic signed [PRICE_W-1:0] last_ff, last_in;
   logic [COUNT_W-1:0]        sig_ff, sig_in, exec_ff, exec_in;
   logic                      sweep_ff, sweep_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic [AW-1:0]             rd_addr_a, rd_addr_b;
   logic [PRICE_W-1:0]        rd_data_a, rd_data_b;

   logic signed [SUM_W-1:0]   price_x, ev_f, ev_s, sweep_x, fsum_n, ssum_n, f_eff;
   logic signed [PROD_W-1:0]  lhs, rhs;
   logic signed [COST_W-1:0]  cost, limit;
   logic                      warm, acc_f, acc_s;
   action_type                act_c;
   cause_type                 cause_c;
   logic                      ok_c;

   logic                      out_valid_ff, out_valid_in;
   action_type                action_ff;
   logic                      accepted_ff;
   cause_type                 cause_ff;

   always_comb begin
      if (cfg.fast_window == '0) begin
         fw = WIN_W'(1);
      end else if (32'(cfg.fast_window) > MAX_WINDOW) begin
         fw = WIN_W'(MAX_WINDOW);
      end else begin
         fw = WIN_W'(cfg.fast_window);
      end
      if (cfg.slow_window == '0) begin
         sw = WIN_W'(1);
      end else if (32'(cfg.slow_window) > MAX_WINDOW) begin
         sw = WIN_W'(MAX_WINDOW);
      end else begin
         sw = WIN_W'(cfg.slow_window);
      end
   end

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !sweep_ff && (!in_valid_ff || advance);
   assign accept       = req_ch.valid && req_ch.ready;

   assign wp_inc    = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + AW'(1);
   assign fill_next = (fill_ff < WIN_W'(MAX_WINDOW)) ? fill_ff + WIN_W'(1) : fill_ff;

   // Prefetch the entries leaving each window on the next transaction, or the resum entry.
   always_comb begin
      if (sweep_ff && (cnt_ff < CNT_W'(MAX_WINDOW))) begin
         rd_addr_a = sub_mod(wp_ff, WIN_W'(cnt_ff) + WIN_W'(1));
      end else begin
         rd_addr_a = sub_mod(wp_in, fw);
      end
      rd_addr_b = sub_mod(wp_in, sw);
   end

   macs_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (MAX_WINDOW)
   ) u_window (
      .clock     (clock),
      .wr_en     (advance),
      .wr_addr   (wp_ff),
      .wr_data   (in_price_ff),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // A window of one drops the price written on the previous transaction.
   assign price_x = SUM_W'(in_price_ff);
   assign ev_f    = (fw == WIN_W'(1)) ? SUM_W'(last_ff) : SUM_W'($signed(rd_data_a));
   assign ev_s    = (sw == WIN_W'(1)) ? SUM_W'(last_ff) : SUM_W'($signed(rd_data_b));
   assign sweep_x = SUM_W'($signed(rd_data_a));

   assign fsum_n = fsum_ff + price_x - ((fill_ff >= fw) ? ev_f : '0);
   assign ssum_n = ssum_ff + price_x - ((fill_ff >= sw) ? ev_s : '0);
   assign f_eff  = (fill_next >= fw) ? fsum_n : '0;
   assign warm   = (fill_next >= sw);
   assign lhs    = f_eff * $signed({1'b0, sw});
   assign rhs    = ssum_n * $signed({1'b0, fw});

   assign cost  = in_price_ff * $signed({1'b0, cfg.order_quantity});
   assign limit = $signed(COST_W'({cfg.account_balance, BAL_SHIFT'(0)}));

   always_comb begin
      act_c = ACT_HOLD;
      if (warm) begin
         priority if (lhs > rhs) begin
            act_c = ACT_BUY;
         end else if (lhs < rhs) begin
            act_c = ACT_SELL;
         end else begin
            act_c = ACT_HOLD;
         end
      end
      cause_c = CAUSE_NONE;
      ok_c    = 1'b0;
      if (act_c != ACT_HOLD) begin
         priority if ((act_c == ACT_BUY) && (cost > limit)) begin
            cause_c = CAUSE_CAPITAL;
         end else if ((in_price_ff <= 32'sd0) || (cfg.order_quantity == '0)) begin
            cause_c = CAUSE_PRICE;
         end else begin
            ok_c = 1'b1;
         end
      end
   end

   assign acc_f = (cnt_ff != '0) && (cnt_ff <= CNT_W'(MAX_WINDOW)) &&
                  (cnt_ff <= CNT_W'(fill_ff)) && (cnt_ff <= CNT_W'(fw));
   assign acc_s = (cnt_ff != '0) && (cnt_ff <= CNT_W'(MAX_WINDOW)) &&
                  (cnt_ff <= CNT_W'(fill_ff)) && (cnt_ff <= CNT_W'(sw));

   always_comb begin
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      fsum_in  = fsum_ff;
      ssum_in  = ssum_ff;
      last_in  = last_ff;
      sig_in   = sig_ff;
      exec_in  = exec_ff;
      sweep_in = sweep_ff;
      cnt_in   = cnt_ff;
      priority if (win_wr) begin
         sweep_in = 1'b1;
         cnt_in   = '0;
         fsum_in  = '0;
         ssum_in  = '0;
      end else if (sweep_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MAX_WINDOW + 1)) begin
            sweep_in = 1'b0;
         end
         if (acc_f) begin
            fsum_in = fsum_ff + sweep_x;
         end
         if (acc_s) begin
            ssum_in = ssum_ff + sweep_x;
         end
      end else if (advance) begin
         wp_in   = wp_inc;
         fill_in = fill_next;
         fsum_in = fsum_n;
         ssum_in = ssum_n;
         last_in = in_price_ff;
         if (act_c != ACT_HOLD) begin
            sig_in = sig_ff + COUNT_W'(1);
         end
         if (ok_c) begin
            exec_in = exec_ff + COUNT_W'(1);
         end
      end else begin
         wp_in = wp_ff;
      end
   end

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         fsum_ff      <= '0;
         ssum_ff      <= '0;
         sig_ff       <= '0;
         exec_ff      <= '0;
         sweep_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         fsum_ff      <= fsum_in;
         ssum_ff      <= ssum_in;
         sig_ff       <= sig_in;
         exec_ff      <= exec_in;
         sweep_ff     <= sweep_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (accept) begin
         in_price_ff <= req_ch.price;
      end
      if (advance) begin
         action_ff   <= act_c;
         accepted_ff <= ok_c;
         cause_ff    <= cause_c;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.action         = action_ff;
   assign rsp_ch.accepted       = accepted_ff;
   assign rsp_ch.reject_cause   = cause_ff;
   assign rsp_ch.order_number   = sig_ff;
   assign rsp_ch.executed_count = exec_ff;

endmodule

@@ hdl/moving_average_cross_signal_top.sv @@
// Moving average crossover signal with pre-trade risk check: one price per clock in, one
// decision per clock out while no stall holds it. Prices pass an input register, then the
// result register; fast and slow sums are kept as running sums fed by a dual-read window
// RAM, so the sustained rate is one transaction per cycle without stalls. A write to
// either window register starts a resum pass over the window RAM, one entry per cycle, and
// req_ch.ready stays low until the pass ends. Other register writes take effect at once.
// Depends on macs_pkg, macs_intf, macs_ram, macs_csr and macs_core.
`timescale 1ns / 1ps

module moving_average_cross_signal_top #(
   parameter int unsigned MAX_WINDOW = macs_pkg::MAX_WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   macs_req_if.sink                        req_ch,
   macs_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [macs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [macs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [macs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import macs_pkg::*;

   cfg_type cfg;
   logic    win_wr;

   macs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg),
      .win_wr  (win_wr)
   );

   macs_core #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cfg    (cfg),
      .win_wr (win_wr)
   );

   assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       ((csr_paddr[3:2] == REG_FAST_WINDOW) || (csr_paddr[3:2] == REG_SLOW_WINDOW)))
      |=> !req_ch.ready)
      else $error("transaction taken during window resum");

   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) ##1 rsp_ch.ready |=> rsp_ch.valid)
      else $error("accepted transaction did not reach the result register");

endmodule

@@ test/tb_top.sv @@
// Testbench for moving_average_cross_signal_top: random price streams with random idling on both
// channels, a predictor of the crossover decision and risk check, and APB register programming.
// Depends on macs_pkg, macs_intf and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
   import macs_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int MAX_WINDOW     = MAX_WINDOW_DEF;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 64;
   localparam longint PRICE_MAX  = 64'sd2147483647;
   localparam longint PRICE_MIN  = -64'sd2147483648;

   typedef struct packed {
      action_type  action;
      logic        accepted;
      cause_type   cause;
      logic [31:0] order_number;
      logic [31:0] executed_count;
   } decision_type;

   typedef struct packed {
      logic [31:0]  price;
      logic         known;
      decision_type decision;
   } tick_row_type;

   localparam decision_type HOLD_AT_START = '{ACT_HOLD, 1'b0, CAUSE_NONE, 32'd0, 32'd0};

   localparam tick_row_type DIRECTED_TICKS [23] = '{
      '{32'h7FFF_FFFF, 1'b1, HOLD_AT_START},
      '{32'h8000_0000, 1'b1, HOLD_AT_START},
      '{32'h0000_0000, 1'b1, HOLD_AT_START},
      '{32'hFFFF_FFFF, 1'b1, HOLD_AT_START},
      '{32'h0000_0001, 1'b1, HOLD_AT_START},
      '{32'h0000_6400, 1'b1, HOLD_AT_START},
      '{32'h0000_6400, 1'b1, HOLD_AT_START},
      '{32'h0000_6400, 1'b1, HOLD_AT_START},
      '{32'h0000_6400, 1'b1, HOLD_AT_START},
      '{32'h0000_6400, 1'b0, HOLD_AT_START},
      '{32'h0007_D000, 1'b0, HOLD_AT_START},
      '{32'hFFFF_9C00, 1'b0, HOLD_AT_START},
      '{32'hFFFF_9C00, 1'b0, HOLD_AT_START},
      '{32'hFFFF_9C00, 1'b0, HOLD_AT_START},
      '{32'hFFFF_9C00, 1'b0, HOLD_AT_START},
      '{32'h0001_F400, 1'b0, HOLD_AT_START},
      '{32'h0001_F400, 1'b0, HOLD_AT_START},
      '{32'h0001_F400, 1'b0, HOLD_AT_START},
      '{32'h0000_C800, 1'b0, HOLD_AT_START},
      '{32'h0000_C800, 1'b0, HOLD_AT_START},
      '{32'h0000_C800, 1'b0, HOLD_AT_START},
      '{32'h7FFF_FFFF, 1'b0, HOLD_AT_START},
      '{32'h8000_0000, 1'b0, HOLD_AT_START}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   macs_req_if req_ch ();
   macs_rsp_if rsp_ch ();

   moving_average_cross_signal_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // predictor state and settings
   logic signed [31:0] tick_history [MAX_WINDOW];
   logic [3:0]  head_pos        = '0;
   int          ticks_seen      = 0;
   logic [31:0] signal_total    = '0;
   logic [31:0] executed_total  = '0;
   logic [4:0]  fast_setting    = FAST_WINDOW_RST;
   logic [4:0]  slow_setting    = SLOW_WINDOW_RST;
   logic [31:0] balance_setting = ACCOUNT_BALANCE_RST;
   logic [15:0] qty_setting     = ORDER_QUANTITY_RST;

   decision_type pending_decisions [$];
   int          error_count       = 0;
   int          ticks_sent        = 0;
   int          decisions_checked = 0;
   int          buy_count         = 0;
   int          sell_count        = 0;
   int          capital_rejects   = 0;
   int          price_rejects     = 0;
   int          settings_applied  = 0;
   int unsigned req_gap_max       = 12;
   int unsigned rsp_gap_max       = 12;
   int          rsp_hold_cycles   = 0;
   int          idle_cycles       = 0;

   longint      walk_level = 0;
   longint      walk_step  = 256;
   int          walk_trend = 1;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic int effective_window(input logic [4:0] setting);
      if (setting == 0) return 1;
      if (setting > MAX_WINDOW) return MAX_WINDOW;
      return int'(setting);
   endfunction

   function automatic longint recent_total(input int count);
      longint     total;
      logic [3:0] slot;
      total = 0;
      for (int k = 0; k < count; k++) begin
         slot  = head_pos - 4'(k + 1);
         total += longint'(tick_history[slot]);
      end
      return total;
   endfunction

   function automatic decision_type predict_decision(input logic signed [31:0] price);
      decision_type d;
      longint    fw;
      longint    sw;
      longint    fast_total;
      longint    slow_total;
      longint    cost;
      longint    limit;
      d  = HOLD_AT_START;
      fw = effective_window(fast_setting);
      sw = effective_window(slow_setting);
      tick_history[head_pos] = price;
      head_pos = head_pos + 4'd1;
      if (ticks_seen < MAX_WINDOW) ticks_seen++;
      fast_total = (ticks_seen >= fw) ? recent_total(int'(fw)) : 0;
      slow_total = (ticks_seen >= sw) ? recent_total(int'(sw)) : 0;
      if (ticks_seen >= sw) begin
         if (fast_total * sw > slow_total * fw) d.action = ACT_BUY;
         else if (fast_total * sw < slow_total * fw) d.action = ACT_SELL;
      end
      if (d.action != ACT_HOLD) begin
         cost  = longint'(price) * longint'(qty_setting);
         limit = longint'(balance_setting) * 256;
         signal_total++;
         if (d.action == ACT_BUY && cost > limit) d.cause = CAUSE_CAPITAL;
         else if (price <= 0 || qty_setting == 0) d.cause = CAUSE_PRICE;
         else begin
            d.accepted = 1'b1;
            executed_total++;
         end
      end
      d.order_number   = signal_total;
      d.executed_count = executed_total;
      return d;
   endfunction

   function automatic logic [31:0] current_setting(input reg_index_type idx);
      case (idx)
         REG_FAST_WINDOW:     return 32'(fast_setting);
         REG_SLOW_WINDOW:     return 32'(slow_setting);
         REG_ACCOUNT_BALANCE: return balance_setting;
         default:             return 32'(qty_setting);
      endcase
   endfunction

   function automatic logic signed [31:0] clamp_price(input longint value);
      if (value > PRICE_MAX) return PRICE_MAX[31:0];
      if (value < PRICE_MIN) return PRICE_MIN[31:0];
      return value[31:0];
   endfunction

   // lowest price at which a buy no longer fits the balance, or 25600 for a zero quantity
   function automatic longint capital_threshold();
      if (qty_setting == 0) return 25600;
      return (longint'(balance_setting) * 256) / longint'(qty_setting) + 1;
   endfunction

   function automatic logic signed [31:0] next_price();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return $urandom;
      if (pick < 20) return int'($urandom_range(0, 2048)) - 1024;
      if (pick < 25) return clamp_price(capital_threshold() + int'($urandom_range(0, 2)) - 1);
      if ($urandom_range(0, 15) == 0) walk_trend = -walk_trend;
      walk_level += walk_trend * longint'($urandom_range(0, int'(walk_step)))
                    + longint'($urandom_range(0, int'(walk_step))) - walk_step / 2;
      if (walk_level > PRICE_MAX) begin
         walk_level = PRICE_MAX;
         walk_trend = -1;
      end else if (walk_level < PRICE_MIN) begin
         walk_level = PRICE_MIN;
         walk_trend = 1;
      end
      return walk_level[31:0];
   endfunction

   task automatic seed_walk();
      case ($urandom_range(0, 3))
         0:       walk_step = 256;
         1:       walk_step = 2560;
         2:       walk_step = 1 << 16;
         default: walk_step = 1 << 24;
      endcase
      if ($urandom_range(0, 1) == 1) walk_level = capital_threshold();
      else walk_level = longint'(signed'($urandom)) / 64;
      if (walk_level > PRICE_MAX) walk_level = PRICE_MAX;
      walk_trend = ($urandom_range(0, 1) == 1) ? 1 : -1;
   endtask

   task automatic send_price(input logic signed [31:0] price, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.price <= price;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic feed_tick(input logic signed [31:0] price, input int gap, input logic known,
                            input decision_type typed);
      decision_type want;
      send_price(price, gap);
      want = predict_decision(price);
      if (known) want = typed;
      pending_decisions.insert(pending_decisions.size(), want);
   endtask

   // hold the input, wait for every pending decision, then let the pipeline settle
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write_en, input reg_index_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic verify_register(input reg_index_type idx);
      logic [31:0] readback;
      csr_access(1'b0, idx, 32'd0, readback);
      if (readback !== current_setting(idx))
         report_mismatch({"readback of ", idx.name()}, readback, current_setting(idx));
   endtask

   task automatic program_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(1'b1, idx, value, unused);
      case (idx)
         REG_FAST_WINDOW:     fast_setting    = value[4:0];
         REG_SLOW_WINDOW:     slow_setting    = value[4:0];
         REG_ACCOUNT_BALANCE: balance_setting = value;
         default:             qty_setting     = value[15:0];
      endcase
      verify_register(idx);
   endtask

   task automatic run_phase(input logic [31:0] fw, input logic [31:0] sw,
                            input logic [31:0] balance, input logic [31:0] qty,
                            input int ticks, input int unsigned req_max,
                            input int unsigned rsp_max, input bit pressure);
      int gap;
      drain_results();
      program_register(REG_FAST_WINDOW, fw);
      program_register(REG_SLOW_WINDOW, sw);
      program_register(REG_ACCOUNT_BALANCE, balance);
      program_register(REG_ORDER_QUANTITY, qty);
      csr_release();
      settings_applied++;
      req_gap_max = req_max;
      rsp_gap_max = rsp_max;
      seed_walk();
      for (int i = 0; i < ticks; i++) begin
         gap = $urandom_range(0, req_gap_max);
         if (pressure && i == 20) rsp_hold_cycles = LONG_HOLD;
         if (pressure && i >= 20 && i < 40) gap = 0;
         if (pressure && i == 60) drain_results();
         feed_tick(next_price(), gap, 1'b0, HOLD_AT_START);
      end
   endtask

   task automatic check_decision();
      decision_type want;
      if (pending_decisions.size() == 0) begin
         report_mismatch("decision with nothing pending", 32'(rsp_ch.action), 32'd0);
         return;
      end
      want = pending_decisions.pop_front();
      decisions_checked++;
      if (rsp_ch.action !== want.action)
         report_mismatch("action", 32'(rsp_ch.action), 32'(want.action));
      if (rsp_ch.accepted !== want.accepted)
         report_mismatch("accepted", 32'(rsp_ch.accepted), 32'(want.accepted));
      if (rsp_ch.reject_cause !== want.cause)
         report_mismatch("reject_cause", 32'(rsp_ch.reject_cause), 32'(want.cause));
      if (rsp_ch.order_number !== want.order_number)
         report_mismatch("order_number", rsp_ch.order_number, want.order_number);
      if (rsp_ch.executed_count !== want.executed_count)
         report_mismatch("executed_count", rsp_ch.executed_count, want.executed_count);
      if (want.action == ACT_BUY) buy_count++;
      if (want.action == ACT_SELL) sell_count++;
      if (want.cause == CAUSE_CAPITAL) capital_rejects++;
      if (want.cause == CAUSE_PRICE) price_rejects++;
   endtask

   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_gap_max);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         check_decision();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles at %0t", idle_cycles, $time);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.price <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r <= int'(REG_ORDER_QUANTITY); r++) verify_register(reg_index_type'(r));
      csr_release();

      foreach (DIRECTED_TICKS[i])
         feed_tick(DIRECTED_TICKS[i].price, $urandom_range(0, req_gap_max),
                   DIRECTED_TICKS[i].known, DIRECTED_TICKS[i].decision);

      run_phase(32'd1, 32'd16, 32'd2560000, 32'd2560, 80, 12, 12, 1'b0);
      run_phase(32'd16, 32'd1, 32'hFFFF_FFFF, 32'h0000_FFFF, 80, 0, 0, 1'b0);
      run_phase(32'd0, 32'd31, 32'd0, 32'd2560, 80, 12, 0, 1'b0);
      run_phase(32'd31, 32'd0, 32'd2560000, 32'd0, 80, 0, 12, 1'b0);
      run_phase(32'd16, 32'd16, 32'd1000, 32'd256, 80, 12, 12, 1'b0);
      run_phase(32'(FAST_WINDOW_RST), 32'(SLOW_WINDOW_RST), 32'(ACCOUNT_BALANCE_RST),
                32'(ORDER_QUANTITY_RST), 80, 12, 12, 1'b1);
      for (int p = 0; p < 5; p++)
         run_phase($urandom, $urandom, $urandom >> $urandom_range(0, 31), $urandom, 80,
                   (p % 2 == 0) ? 12 : 0, 12, 1'b0);

      drain_results();
      if (pending_decisions.size() != 0)
         report_mismatch("decisions never delivered", pending_decisions.size(), 32'd0);

      $display("Run covered %0d ticks and %0d decisions over %0d register settings",
               ticks_sent, decisions_checked, settings_applied);
      $display("Buys %0d, sells %0d, capital rejects %0d, price rejects %0d, mismatches %0d",
               buy_count, sell_count, capital_rejects, price_rejects, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
